// ===== src/filled_midpoint_ellipse_stepper_defines.svh =====
`ifndef FILLED_MIDPOINT_ELLIPSE_STEPPER_DEFINES_SVH
`define FILLED_MIDPOINT_ELLIPSE_STEPPER_DEFINES_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define FMES_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define FMES_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/fmes_pkg.sv =====
`timescale 1ns / 1ps

package fmes_pkg;

   localparam int COORD_BITS_DEF = 12;

   localparam logic CMD_START = 1'b0;
   localparam logic CMD_STEP  = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_S_RX2,
      ST_S_RY2,
      ST_S_RXRY,
      ST_S_DEC,
      ST_R2_TX,
      ST_R2_A,
      ST_R2_YM,
      ST_R2_B,
      ST_R2_C,
      ST_R2_DEC,
      ST_STEP,
      ST_STEP_DEC,
      ST_EMIT
   } state_type;

endpackage

// ===== src/filled_midpoint_ellipse_stepper.sv =====
`timescale 1ns / 1ps

// Channel  | Direction | Handshake           | Payload
// req      | in        | req_valid/req_stall | cmd, center_x, center_y, edge_x, edge_y
// rsp      | out       | rsp_valid/rsp_stall | plot, left_x, right_x, top_y, bottom_y, last
//
// Start: three passes through the shared multiplier from accept to result.
// Step: STEP, STEP_DEC; the step that enters region two first runs R2_TX to R2_DEC
// (five multiplies on one multiplier form the new decision term). Idle step: to EMIT.
// One item at a time; a new item is taken while the previous result still waits.
// Reset is synchronous; it clears the sequencer, busy and region flags and rsp_valid.
// A stalled result holds; a finished item waits for the output register to free.

module filled_midpoint_ellipse_stepper
   import fmes_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_cmd,
   input  logic [COORD_BITS-1:0]        req_center_x,
   input  logic [COORD_BITS-1:0]        req_center_y,
   input  logic [COORD_BITS-1:0]        req_edge_x,
   input  logic [COORD_BITS-1:0]        req_edge_y,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_plot,
   output logic signed [COORD_BITS:0]   rsp_left_x,
   output logic [COORD_BITS:0]          rsp_right_x,
   output logic signed [COORD_BITS:0]   rsp_top_y,
   output logic [COORD_BITS:0]          rsp_bottom_y,
   output logic                         rsp_last
);

   localparam int CW = COORD_BITS;
   localparam int OW = CW + 1;
   localparam int XW = CW + 1;
   localparam int SW = 3 * CW + 3;
   localparam int MW = 2 * CW + 4;
   localparam int DW = 2 * MW;

   state_type state_ff, state_in;

   logic            busy_ff, busy_in;
   logic            region_ff, region_in;
   logic            plot_ff, plot_in;
   logic            choice_ff, choice_in;
   logic [CW-1:0]   cx_ff, cx_in, cy_ff, cy_in;
   logic [CW-1:0]   rx_ff, rx_in, ry_ff, ry_in;
   logic [2*CW-1:0] rx2_ff, rx2_in, ry2_ff, ry2_in;
   logic [XW-1:0]   x_ff, x_in;
   logic [CW-1:0]   y_ff, y_in;
   logic [SW-1:0]   stx_ff, stx_in, sty_ff, sty_in;
   logic [DW-1:0]   dec_ff, dec_in;
   logic [DW-1:0]   acc_ff, acc_in;

   logic            rsp_valid_ff, rsp_valid_in;
   logic            rsp_plot_ff, rsp_plot_in;
   logic [OW-1:0]   rsp_left_ff, rsp_left_in;
   logic [OW-1:0]   rsp_right_ff, rsp_right_in;
   logic [OW-1:0]   rsp_top_ff, rsp_top_in;
   logic [OW-1:0]   rsp_bottom_ff, rsp_bottom_in;
   logic            rsp_last_ff, rsp_last_in;

   logic [MW-1:0]   mul_a, mul_b;
   logic [DW-1:0]   prod_ff;

   logic            req_xfer;
   logic [CW+1:0]   tx;
   logic [CW-1:0]   ym;
   logic [SW-1:0]   two_rx2, two_ry2;
   logic [DW-1:0]   quarter;

   function automatic logic [DW-1:0] quarter_trunc(input logic [DW-1:0] q);
      logic [DW-1:0] mag;
      mag = q[DW-1] ? (~q + DW'(1)) : q;
      mag = mag >> 2;
      return q[DW-1] ? (~mag + DW'(1)) : mag;
   endfunction

   fmes_mul #(
      .OPND_BITS(MW)
   ) u_mul (
      .clock  (clock),
      .mul_a  (mul_a),
      .mul_b  (mul_b),
      .prod_ff(prod_ff)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;

   assign tx      = {x_ff, 1'b1};
   assign ym      = y_ff - CW'(1);
   assign two_rx2 = SW'({rx2_ff, 1'b0});
   assign two_ry2 = SW'({ry2_ff, 1'b0});

   always_comb begin
      state_in      = state_ff;
      busy_in       = busy_ff;
      region_in     = region_ff;
      plot_in       = plot_ff;
      choice_in     = choice_ff;
      cx_in         = cx_ff;
      cy_in         = cy_ff;
      rx_in         = rx_ff;
      ry_in         = ry_ff;
      rx2_in        = rx2_ff;
      ry2_in        = ry2_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      stx_in        = stx_ff;
      sty_in        = sty_ff;
      dec_in        = dec_ff;
      acc_in        = acc_ff;
      quarter       = '0;
      mul_a         = '0;
      mul_b         = '0;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_plot_in   = rsp_plot_ff;
      rsp_left_in   = rsp_left_ff;
      rsp_right_in  = rsp_right_ff;
      rsp_top_in    = rsp_top_ff;
      rsp_bottom_in = rsp_bottom_ff;
      rsp_last_in   = rsp_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if (req_cmd == CMD_START) begin
                  cx_in    = req_center_x;
                  cy_in    = req_center_y;
                  rx_in    = (req_edge_x >= req_center_x) ? req_edge_x - req_center_x
                                                         : req_center_x - req_edge_x;
                  ry_in    = (req_edge_y >= req_center_y) ? req_edge_y - req_center_y
                                                         : req_center_y - req_edge_y;
                  plot_in  = 1'b1;
                  state_in = ST_S_RX2;
               end else if (!busy_ff) begin
                  plot_in  = 1'b0;
                  state_in = ST_EMIT;
               end else if (!region_ff && !(stx_ff < sty_ff)) begin
                  plot_in  = 1'b1;
                  state_in = ST_R2_TX;
               end else begin
                  plot_in  = 1'b1;
                  state_in = ST_STEP;
               end
            end
         end
         ST_S_RX2: begin
            mul_a    = MW'(rx_ff);
            mul_b    = MW'(rx_ff);
            state_in = ST_S_RY2;
         end
         ST_S_RY2: begin
            rx2_in   = prod_ff[2*CW-1:0];
            mul_a    = MW'(ry_ff);
            mul_b    = MW'(ry_ff);
            state_in = ST_S_RXRY;
         end
         ST_S_RXRY: begin
            ry2_in   = prod_ff[2*CW-1:0];
            mul_a    = MW'(rx2_ff);
            mul_b    = MW'(ry_ff);
            state_in = ST_S_DEC;
         end
         ST_S_DEC: begin
            sty_in    = SW'({prod_ff, 1'b0});
            stx_in    = '0;
            x_in      = '0;
            y_in      = ry_ff;
            region_in = 1'b0;
            quarter   = DW'(2) + DW'({ry2_ff, 2'b00}) - {prod_ff[DW-3:0], 2'b00}
                        + DW'(rx2_ff);
            dec_in    = quarter_trunc(quarter);
            state_in  = ST_EMIT;
         end
         ST_R2_TX: begin
            mul_a    = MW'(tx);
            mul_b    = MW'(tx);
            state_in = ST_R2_A;
         end
         ST_R2_A: begin
            mul_a    = MW'(ry2_ff);
            mul_b    = prod_ff[MW-1:0];
            state_in = ST_R2_YM;
         end
         ST_R2_YM: begin
            acc_in   = prod_ff + DW'(2);
            mul_a    = MW'(ym);
            mul_b    = MW'(ym);
            state_in = ST_R2_B;
         end
         ST_R2_B: begin
            mul_a    = MW'(rx2_ff);
            mul_b    = prod_ff[MW-1:0];
            state_in = ST_R2_C;
         end
         ST_R2_C: begin
            acc_in   = acc_ff + {prod_ff[DW-3:0], 2'b00};
            mul_a    = MW'(rx2_ff);
            mul_b    = MW'(ry2_ff);
            state_in = ST_R2_DEC;
         end
         ST_R2_DEC: begin
            quarter   = acc_ff - {prod_ff[DW-3:0], 2'b00};
            dec_in    = quarter_trunc(quarter);
            region_in = 1'b1;
            state_in  = ST_STEP;
         end
         ST_STEP: begin
            if (!region_ff) begin
               x_in      = x_ff + XW'(1);
               stx_in    = stx_ff + two_ry2;
               choice_in = !dec_ff[DW-1];
               if (!dec_ff[DW-1]) begin
                  y_in   = ym;
                  sty_in = sty_ff - two_rx2;
               end
            end else begin
               y_in      = ym;
               sty_in    = sty_ff - two_rx2;
               choice_in = dec_ff[DW-1] || (dec_ff == '0);
               if (dec_ff[DW-1] || (dec_ff == '0)) begin
                  x_in   = x_ff + XW'(1);
                  stx_in = stx_ff + two_ry2;
               end
            end
            state_in = ST_STEP_DEC;
         end
         ST_STEP_DEC: begin
            if (!region_ff) begin
               dec_in = dec_ff + DW'(ry2_ff) + DW'(stx_ff)
                        - (choice_ff ? DW'(sty_ff) : DW'(0));
            end else begin
               dec_in = dec_ff + DW'(rx2_ff) - DW'(sty_ff)
                        + (choice_ff ? DW'(stx_ff) : DW'(0));
            end
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_plot_in  = plot_ff;
               if (plot_ff) begin
                  rsp_left_in   = {1'b0, cx_ff} - x_ff;
                  rsp_right_in  = {1'b0, cx_ff} + x_ff;
                  rsp_top_in    = {1'b0, cy_ff} - {1'b0, y_ff};
                  rsp_bottom_in = {1'b0, cy_ff} + {1'b0, y_ff};
                  rsp_last_in   = (y_ff == '0);
                  busy_in       = (y_ff != '0);
               end else begin
                  rsp_left_in   = '0;
                  rsp_right_in  = '0;
                  rsp_top_in    = '0;
                  rsp_bottom_in = '0;
                  rsp_last_in   = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         busy_ff      <= 1'b0;
         region_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         busy_ff      <= busy_in;
         region_ff    <= region_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      plot_ff       <= plot_in;
      choice_ff     <= choice_in;
      cx_ff         <= cx_in;
      cy_ff         <= cy_in;
      rx_ff         <= rx_in;
      ry_ff         <= ry_in;
      rx2_ff        <= rx2_in;
      ry2_ff        <= ry2_in;
      x_ff          <= x_in;
      y_ff          <= y_in;
      stx_ff        <= stx_in;
      sty_ff        <= sty_in;
      dec_ff        <= dec_in;
      acc_ff        <= acc_in;
      rsp_plot_ff   <= rsp_plot_in;
      rsp_left_ff   <= rsp_left_in;
      rsp_right_ff  <= rsp_right_in;
      rsp_top_ff    <= rsp_top_in;
      rsp_bottom_ff <= rsp_bottom_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_plot     = rsp_plot_ff;
   assign rsp_left_x   = $signed(rsp_left_ff);
   assign rsp_right_x  = rsp_right_ff;
   assign rsp_top_y    = $signed(rsp_top_ff);
   assign rsp_bottom_y = rsp_bottom_ff;
   assign rsp_last     = rsp_last_ff;

endmodule

// ===== src/fmes_mul.sv =====
`timescale 1ns / 1ps

module fmes_mul
   import fmes_pkg::*;
#(
   parameter int OPND_BITS = 2 * COORD_BITS_DEF + 4
) (
   input  logic                       clock,
   input  logic [OPND_BITS-1:0]       mul_a,
   input  logic [OPND_BITS-1:0]       mul_b,
   output logic [2*OPND_BITS-1:0]     prod_ff
);

   logic [2*OPND_BITS-1:0] prod_in;

   assign prod_in = mul_a * mul_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

// ===== src/fmes_checker.sv =====
`timescale 1ns / 1ps

`include "filled_midpoint_ellipse_stepper_defines.svh"

module fmes_checker
   import fmes_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic                         rsp_plot,
   input logic signed [COORD_BITS:0]   rsp_left_x,
   input logic [COORD_BITS:0]          rsp_right_x,
   input logic signed [COORD_BITS:0]   rsp_top_y,
   input logic [COORD_BITS:0]          rsp_bottom_y,
   input logic                         rsp_last
);

   logic [COORD_BITS:0] top_bits;
   logic                idle_empty;
   logic                last_set;
   logic                on_center_row;

   assign top_bits      = rsp_top_y;
   assign idle_empty    = rsp_last && (rsp_left_x == '0) && (rsp_right_x == '0)
                          && (rsp_top_y == '0) && (rsp_bottom_y == '0);
   assign last_set      = rsp_valid && rsp_plot && rsp_last;
   assign on_center_row = (top_bits == rsp_bottom_y);

   // hold a stalled result
   `FMES_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid, "rsp dropped while stalled")

   // one item at a time: a transfer in closes the request side
   `FMES_ASSERT_NEXT(a_req_busy, req_valid && !req_stall, req_stall, "req taken while working")

   `FMES_ASSERT_NOW(a_idle_rsp, rsp_valid && !rsp_plot, idle_empty, "idle result not empty")

   `FMES_ASSERT_NOW(a_last_row, last_set, on_center_row, "last point set off the center row")

endmodule

bind filled_midpoint_ellipse_stepper fmes_checker #(.COORD_BITS(COORD_BITS)) u_fmes_checker (.*);

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import fmes_pkg::*;

   localparam int CW             = COORD_BITS_DEF;
   localparam int MAXC           = (1 << CW) - 1;
   localparam int RANDOM_ITEMS   = 600;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 20;
   localparam int PRINT_CAP      = 40;

   typedef struct {
      logic          cmd;
      logic [CW-1:0] center_x;
      logic [CW-1:0] center_y;
      logic [CW-1:0] edge_x;
      logic [CW-1:0] edge_y;
   } ellipse_cmd_t;

   typedef struct {
      logic        plot;
      logic [CW:0] left_x;
      logic [CW:0] right_x;
      logic [CW:0] top_y;
      logic [CW:0] bottom_y;
      logic        last;
   } point_set_t;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic                 req_cmd = CMD_STEP;
   logic [CW-1:0]        req_center_x = '0;
   logic [CW-1:0]        req_center_y = '0;
   logic [CW-1:0]        req_edge_x = '0;
   logic [CW-1:0]        req_edge_y = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic                 rsp_plot;
   logic signed [CW:0]   rsp_left_x;
   logic [CW:0]          rsp_right_x;
   logic signed [CW:0]   rsp_top_y;
   logic [CW:0]          rsp_bottom_y;
   logic                 rsp_last;

   ellipse_cmd_t pending_cmds[$];
   point_set_t   expected_points[$];
   int           total_items = 0;
   int           accepted_items = 0;
   int           mismatch_count = 0;
   int           req_idle_left = 0;
   int           stall_left = 0;
   int           free_left = 0;
   int           quiet_cycles = 0;
   logic         calm = 1'b0;

   // Walk state mirrored from the block.
   bit        walking;
   bit        second_region;
   bit [63:0] walk_col, walk_row, walk_x, walk_y;
   bit [63:0] rx_sq, ry_sq, slope_x, slope_y, decision_term;

   filled_midpoint_ellipse_stepper dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_cmd      (req_cmd),
      .req_center_x (req_center_x),
      .req_center_y (req_center_y),
      .req_edge_x   (req_edge_x),
      .req_edge_y   (req_edge_y),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_plot     (rsp_plot),
      .rsp_left_x   (rsp_left_x),
      .rsp_right_x  (rsp_right_x),
      .rsp_top_y    (rsp_top_y),
      .rsp_bottom_y (rsp_bottom_y),
      .rsp_last     (rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (calm || roll < 50) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic bit [63:0] quarter_to_unit(bit [63:0] q);
      if (q[63]) return 64'd0 - ((64'd0 - q) >> 2);
      return q >> 2;
   endfunction

   task automatic flag_mismatch(string what);
      if (mismatch_count < PRINT_CAP) $display("%0t: %s", $time, what);
      mismatch_count++;
   endtask

   task automatic check_field(string name, logic [CW:0] got, logic [CW:0] want);
      if (got !== want) flag_mismatch($sformatf("rsp_%s got %0h want %0h", name, got, want));
   endtask

   task automatic record_points(bit plot);
      point_set_t p;
      bit [63:0]  v;
      p = '{default: '0};
      p.plot = plot;
      p.last = 1'b1;
      if (plot) begin
         v = walk_col - walk_x;
         p.left_x = v[CW:0];
         v = walk_col + walk_x;
         p.right_x = v[CW:0];
         v = walk_row - walk_y;
         p.top_y = v[CW:0];
         v = walk_row + walk_y;
         p.bottom_y = v[CW:0];
         p.last = (walk_y == 0);
         walking = (walk_y != 0);
      end
      expected_points.push_back(p);
   endtask

   task automatic predict_point_set(ellipse_cmd_t c);
      bit [63:0] rx, ry, q, tx, ym;
      if (c.cmd == CMD_START) begin
         rx = (c.edge_x >= c.center_x) ? 64'(c.edge_x - c.center_x)
                                       : 64'(c.center_x - c.edge_x);
         ry = (c.edge_y >= c.center_y) ? 64'(c.edge_y - c.center_y)
                                       : 64'(c.center_y - c.edge_y);
         walk_col = 64'(c.center_x);
         walk_row = 64'(c.center_y);
         rx_sq = rx * rx;
         ry_sq = ry * ry;
         second_region = 1'b0;
         walk_x = 0;
         walk_y = ry;
         slope_x = 0;
         slope_y = 64'd2 * rx_sq * ry;
         q = 64'd2 + 64'd4 * ry_sq - 64'd4 * rx_sq * ry + rx_sq;
         decision_term = quarter_to_unit(q);
         record_points(1'b1);
      end else if (!walking) begin
         record_points(1'b0);
      end else begin
         if (!second_region && !(slope_x < slope_y)) begin
            tx = 64'd2 * walk_x + 64'd1;
            ym = walk_y - 64'd1;
            second_region = 1'b1;
            q = 64'd2 + ry_sq * tx * tx + 64'd4 * rx_sq * ym * ym - 64'd4 * rx_sq * ry_sq;
            decision_term = quarter_to_unit(q);
         end
         if (!second_region) begin
            walk_x = walk_x + 1;
            slope_x = slope_x + 64'd2 * ry_sq;
            if (decision_term[63]) begin
               decision_term = decision_term + ry_sq + slope_x;
            end else begin
               walk_y = walk_y - 1;
               slope_y = slope_y - 64'd2 * rx_sq;
               decision_term = decision_term + ry_sq + slope_x - slope_y;
            end
         end else begin
            walk_y = walk_y - 1;
            slope_y = slope_y - 64'd2 * rx_sq;
            if (!decision_term[63] && decision_term != 0) begin
               decision_term = decision_term + rx_sq - slope_y;
            end else begin
               walk_x = walk_x + 1;
               slope_x = slope_x + 64'd2 * ry_sq;
               decision_term = decision_term + rx_sq - slope_y + slope_x;
            end
         end
         record_points(1'b1);
      end
   endtask

   task automatic queue_start(int cx, int cy, int ex, int ey);
      ellipse_cmd_t c;
      c.cmd      = CMD_START;
      c.center_x = cx[CW-1:0];
      c.center_y = cy[CW-1:0];
      c.edge_x   = ex[CW-1:0];
      c.edge_y   = ey[CW-1:0];
      pending_cmds.push_back(c);
   endtask

   task automatic queue_steps(int n);
      ellipse_cmd_t c;
      repeat (n) begin
         c.cmd      = CMD_STEP;
         c.center_x = CW'($urandom_range(0, MAXC));
         c.center_y = CW'($urandom_range(0, MAXC));
         c.edge_x   = CW'($urandom_range(0, MAXC));
         c.edge_y   = CW'($urandom_range(0, MAXC));
         pending_cmds.push_back(c);
      end
   endtask

   function automatic int edge_from(int c, int r);
      if ($urandom_range(0, 1)) begin
         if (c + r <= MAXC) return c + r;
         if (c - r >= 0) return c - r;
      end else begin
         if (c - r >= 0) return c - r;
         if (c + r <= MAXC) return c + r;
      end
      return (c >= (MAXC + 1) / 2) ? 0 : MAXC;
   endfunction

   // Request driver: hold a stalled transfer, otherwise advance.
   always @(posedge clock) begin : req_driver
      ellipse_cmd_t c;
      if (reset) begin
         req_valid     <= 1'b0;
         req_idle_left <= 0;
      end else if (!req_valid || !req_stall) begin
         if (req_idle_left != 0) begin
            req_valid     <= 1'b0;
            req_idle_left <= req_idle_left - 1;
         end else if (pending_cmds.size() != 0) begin
            c = pending_cmds.pop_front();
            req_cmd       <= c.cmd;
            req_center_x  <= c.center_x;
            req_center_y  <= c.center_y;
            req_edge_x    <= c.edge_x;
            req_edge_y    <= c.edge_y;
            req_valid     <= 1'b1;
            req_idle_left <= pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if ($urandom_range(0, 299) == 0) calm <= ~calm;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
         free_left  <= 0;
      end else if (stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (free_left != 0) begin
         rsp_stall <= 1'b0;
         free_left <= free_left - 1;
      end else begin
         rsp_stall  <= 1'b0;
         stall_left <= pick_gap();
         free_left  <= ($urandom_range(0, 9) == 0) ? $urandom_range(30, 120)
                                                   : $urandom_range(0, 12);
      end
   end

   always @(posedge clock) begin : monitor
      ellipse_cmd_t c;
      point_set_t   want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            c.cmd      = req_cmd;
            c.center_x = req_center_x;
            c.center_y = req_center_y;
            c.edge_x   = req_edge_x;
            c.edge_y   = req_edge_y;
            predict_point_set(c);
            accepted_items++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_points.size() == 0) begin
               flag_mismatch("rsp transfer with no point set pending");
            end else begin
               want = expected_points.pop_front();
               check_field("plot", (CW+1)'(rsp_plot), (CW+1)'(want.plot));
               check_field("left_x", rsp_left_x, want.left_x);
               check_field("right_x", rsp_right_x, want.right_x);
               check_field("top_y", rsp_top_y, want.top_y);
               check_field("bottom_y", rsp_bottom_y, want.bottom_y);
               check_field("last", (CW+1)'(rsp_last), (CW+1)'(want.last));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      int kind, rx, ry, cx, cy, steps, target;
      walking       = 1'b0;
      second_region = 1'b0;
      walk_col      = 0;
      walk_row      = 0;
      walk_x        = 0;
      walk_y        = 0;
      rx_sq         = 0;
      ry_sq         = 0;
      slope_x       = 0;
      slope_y       = 0;
      decision_term = 0;

      queue_steps(1);
      queue_start(0, 0, MAXC, MAXC);
      queue_steps(3);
      queue_start(MAXC, MAXC, 0, 0);
      queue_steps(2);
      queue_start(100, 200, 300, 200);
      queue_steps(1);
      queue_start(50, 60, 50, 63);
      queue_steps(4);
      queue_start(MAXC, MAXC, MAXC, MAXC);
      queue_start(1000, 1000, 1005, 1003);
      queue_steps(2);
      queue_start(2000, 2100, 2700, 1500);
      queue_steps(2);

      target = pending_cmds.size() + RANDOM_ITEMS;
      while (pending_cmds.size() < target) begin
         kind = $urandom_range(0, 99);
         if (kind < 6) begin
            queue_steps($urandom_range(1, 4));
         end else begin
            if (kind < 84) begin
               rx    = $urandom_range(0, 24);
               ry    = $urandom_range(0, 24);
               steps = rx + ry + $urandom_range(0, 2);
               if ($urandom_range(0, 9) == 0) steps = $urandom_range(0, steps);
            end else if (kind < 95) begin
               rx    = $urandom_range(25, 300);
               ry    = $urandom_range(25, 300);
               steps = $urandom_range(3, 30);
            end else begin
               rx    = $urandom_range(0, MAXC);
               ry    = $urandom_range(0, MAXC);
               steps = $urandom_range(3, 20);
            end
            cx = $urandom_range(0, MAXC);
            cy = $urandom_range(0, MAXC);
            queue_start(cx, cy, edge_from(cx, rx), edge_from(cy, ry));
            queue_steps(steps);
         end
      end
      total_items = pending_cmds.size();

      while (accepted_items < total_items) @(negedge clock);
      while (expected_points.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
